### sv/event_ack_scoreboard_defines.svh
// Assertion macros for the event acknowledge scoreboard.
// Used by the top level; relies on clk_i and rst_ni in the including scope.
`ifndef EVENT_ACK_SCOREBOARD_DEFINES_SVH
`define EVENT_ACK_SCOREBOARD_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define EAS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define EAS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### sv/eas_pkg.sv
// Shared types and constants of the event acknowledge scoreboard.
// No dependencies; used by eas_ctrl, eas_dp and event_ack_scoreboard.
`timescale 1ns / 1ps

package eas_pkg;

  // Default slot and mask geometry.
  localparam int DEF_SERIAL_PORTS  = 4;
  localparam int DEF_TEMP_CHANNELS = 4;
  localparam int DEF_CONSUMERS     = 8;
  localparam int DEF_CHANGE_BITS   = 8;

  // Fixed field widths.
  localparam int OP_W      = 3;
  localparam int SLOT_W    = 8;
  localparam int REV_W     = 16;
  localparam int ID_W      = 32;
  localparam int MASK_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int PEND_W    = 4;

  typedef enum logic [OP_W-1:0] {
    OP_RAISE_SERIAL = 3'd0,
    OP_RAISE_TEMP   = 3'd1,
    OP_ACK          = 3'd2,
    OP_GET_SERIAL   = 3'd3,
    OP_GET_TEMP     = 3'd4
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SERIAL_REQ  = 2'd0,
    CFG_TEMP_REQ    = 2'd1,
    CFG_TEMP_SUP    = 2'd2,
    CFG_CHG_ALLOWED = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    CTRL_IDLE = 1'b0,
    CTRL_EXEC = 1'b1
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the input item
    logic execute;  // apply the latched item and register its result
  } ctrl_cmd_t;

  // Low n bits set, clipped to the mask width.
  function automatic logic [MASK_W-1:0] low_ones(input int n);
    logic [MASK_W:0] t;
    t = ((MASK_W+1)'(1) << n) - (MASK_W+1)'(1);
    return (n >= MASK_W) ? {MASK_W{1'b1}} : t[MASK_W-1:0];
  endfunction

endpackage

### sv/eas_ctrl.sv
// Controller of the event acknowledge scoreboard: accept, execute, strobe.
// Depends on eas_pkg.
`timescale 1ns / 1ps

module eas_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output logic              result_valid_o,
  output eas_pkg::ctrl_cmd_t cmd_o
);

  eas_pkg::ctrl_state_e state_q, state_d;
  logic strobe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= eas_pkg::CTRL_IDLE;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= cmd_o.execute;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    busy          = 1'b0;
    unique case (state_q)
      eas_pkg::CTRL_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = eas_pkg::CTRL_EXEC;
        end
      end
      eas_pkg::CTRL_EXEC: begin
        busy          = 1'b1;
        cmd_o.execute = 1'b1;
        state_d       = eas_pkg::CTRL_IDLE;
      end
      default: state_d = eas_pkg::CTRL_IDLE;
    endcase
  end

  assign result_valid_o = strobe_q;

endmodule

### sv/eas_dp.sv
// Datapath of the event acknowledge scoreboard: slot stores, id counter,
// configuration masks and result registers. Depends on eas_pkg.
`timescale 1ns / 1ps

module eas_dp #(
  parameter int SERIAL_PORTS  = eas_pkg::DEF_SERIAL_PORTS,
  parameter int TEMP_CHANNELS = eas_pkg::DEF_TEMP_CHANNELS,
  parameter int CONSUMERS     = eas_pkg::DEF_CONSUMERS,
  parameter int CHANGE_BITS   = eas_pkg::DEF_CHANGE_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  eas_pkg::ctrl_cmd_t              cmd_i,
  input  logic                            cfg_we_i,
  input  logic [eas_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [eas_pkg::MASK_W-1:0]      cfg_data_i,
  input  logic [eas_pkg::OP_W-1:0]        opcode_i,
  input  logic [eas_pkg::SLOT_W-1:0]      slot_index_i,
  input  logic [eas_pkg::REV_W-1:0]       revision_i,
  input  logic [eas_pkg::MASK_W-1:0]      change_bits_i,
  input  logic [eas_pkg::ID_W-1:0]        ack_event_id_i,
  input  logic [eas_pkg::MASK_W-1:0]      consumer_mask_i,
  output logic                            ok_o,
  output logic [eas_pkg::ID_W-1:0]        out_event_id_o,
  output logic [eas_pkg::REV_W-1:0]       out_revision_o,
  output logic [eas_pkg::MASK_W-1:0]      out_required_o,
  output logic [eas_pkg::MASK_W-1:0]      out_completed_o,
  output logic [eas_pkg::MASK_W-1:0]      out_change_bits_o,
  output logic [eas_pkg::PEND_W-1:0]      serial_pending_o,
  output logic [eas_pkg::PEND_W-1:0]      temp_pending_o
);

  localparam int SIDX_W = (SERIAL_PORTS > 1) ? $clog2(SERIAL_PORTS) : 1;
  localparam int TIDX_W = (TEMP_CHANNELS > 1) ? $clog2(TEMP_CHANNELS) : 1;
  localparam int MW = eas_pkg::MASK_W;
  localparam int IW = eas_pkg::ID_W;
  localparam logic [MW-1:0] CONS_MASK = eas_pkg::low_ones(CONSUMERS);
  localparam logic [MW-1:0] CHG_MASK  = eas_pkg::low_ones(CHANGE_BITS);

  // Latched item.
  logic [eas_pkg::OP_W-1:0]   op_q;
  logic [eas_pkg::SLOT_W-1:0] idx_q;
  logic [eas_pkg::REV_W-1:0]  rev_q;
  logic [MW-1:0]              chg_q;
  logic [IW-1:0]              eid_q;
  logic [MW-1:0]              cm_q;

  // Configuration masks.
  logic [MW-1:0] ser_req_mask_q, tmp_req_mask_q, tmp_sup_mask_q, chg_allow_q;
  logic [MW-1:0] cfg_v;

  // Slot stores.
  logic [SERIAL_PORTS-1:0]  ser_valid_q, ser_valid_d;
  logic [IW-1:0]            ser_id_q   [SERIAL_PORTS];
  logic [eas_pkg::REV_W-1:0] ser_rev_q [SERIAL_PORTS];
  logic [MW-1:0]            ser_req_q  [SERIAL_PORTS];
  logic [MW-1:0]            ser_done_q [SERIAL_PORTS];
  logic [TEMP_CHANNELS-1:0] tmp_valid_q, tmp_valid_d;
  logic [IW-1:0]            tmp_id_q   [TEMP_CHANNELS];
  logic [eas_pkg::REV_W-1:0] tmp_rev_q [TEMP_CHANNELS];
  logic [MW-1:0]            tmp_req_q  [TEMP_CHANNELS];
  logic [MW-1:0]            tmp_done_q [TEMP_CHANNELS];
  logic [MW-1:0]            tmp_chg_q  [TEMP_CHANNELS];

  logic [IW-1:0] next_id_q, id_inc, new_id;

  // Lookup and decision signals.
  logic [SIDX_W-1:0]        s_sel;
  logic [TIDX_W-1:0]        t_sel;
  logic                     s_in_range, t_in_range;
  logic [SERIAL_PORTS-1:0]  s_hit, s_first;
  logic [TEMP_CHANNELS-1:0] t_hit, t_first;
  logic [MW-1:0]            s_req_m, s_done_m, t_req_m, t_done_m;
  logic [MW-1:0]            sel_req, sel_done, new_done;
  logic                     found_s, found_t, ack_ok, ack_complete;
  logic                     do_ser_raise, do_tmp_raise, do_ack_s, do_ack_t;

  // Result values.
  logic              res_ok;
  logic [IW-1:0]     res_id;
  logic [eas_pkg::REV_W-1:0] res_rev;
  logic [MW-1:0]     res_req, res_done, res_chg;

  assign s_in_range = idx_q < eas_pkg::SLOT_W'(SERIAL_PORTS);
  assign t_in_range = idx_q < eas_pkg::SLOT_W'(TEMP_CHANNELS);
  assign s_sel      = idx_q[SIDX_W-1:0];
  assign t_sel      = idx_q[TIDX_W-1:0];
  assign id_inc     = next_id_q + IW'(1);
  assign new_id     = (id_inc == '0) ? IW'(1) : id_inc;

  // Id match over all slots, lowest index first.
  always_comb begin
    for (int i = 0; i < SERIAL_PORTS; i++) begin
      s_hit[i] = ser_valid_q[i] && (ser_id_q[i] == eid_q);
    end
    for (int i = 0; i < TEMP_CHANNELS; i++) begin
      t_hit[i] = tmp_valid_q[i] && (tmp_id_q[i] == eid_q);
    end
    s_first = s_hit & (~s_hit + SERIAL_PORTS'(1));
    t_first = t_hit & (~t_hit + TEMP_CHANNELS'(1));
    s_req_m  = '0;
    s_done_m = '0;
    t_req_m  = '0;
    t_done_m = '0;
    for (int i = 0; i < SERIAL_PORTS; i++) begin
      s_req_m  = s_req_m  | ({MW{s_first[i]}} & ser_req_q[i]);
      s_done_m = s_done_m | ({MW{s_first[i]}} & ser_done_q[i]);
    end
    for (int i = 0; i < TEMP_CHANNELS; i++) begin
      t_req_m  = t_req_m  | ({MW{t_first[i]}} & tmp_req_q[i]);
      t_done_m = t_done_m | ({MW{t_first[i]}} & tmp_done_q[i]);
    end
    found_s      = |s_hit;
    found_t      = |t_hit;
    sel_req      = found_s ? s_req_m : t_req_m;
    sel_done     = found_s ? s_done_m : t_done_m;
    ack_ok       = (eid_q != '0) && (cm_q != '0) && (found_s || found_t) &&
                   ((cm_q & ~sel_req) == '0);
    new_done     = sel_done | cm_q;
    ack_complete = (new_done & sel_req) == sel_req;
  end

  // Operation decode.
  always_comb begin
    do_ser_raise = 1'b0;
    do_tmp_raise = 1'b0;
    do_ack_s     = 1'b0;
    do_ack_t     = 1'b0;
    res_ok       = 1'b0;
    res_id       = '0;
    res_rev      = '0;
    res_req      = '0;
    res_done     = '0;
    res_chg      = '0;
    unique case (op_q)
      eas_pkg::OP_RAISE_SERIAL: begin
        if (s_in_range) begin
          do_ser_raise = 1'b1;
          res_ok       = 1'b1;
          res_id       = new_id;
        end
      end
      eas_pkg::OP_RAISE_TEMP: begin
        if (t_in_range && (rev_q != '0) && (chg_q != '0) &&
            ((chg_q & ~chg_allow_q) == '0) && !tmp_valid_q[t_sel]) begin
          do_tmp_raise = 1'b1;
          res_ok       = 1'b1;
          res_id       = new_id;
        end
      end
      eas_pkg::OP_ACK: begin
        if (ack_ok) begin
          do_ack_s = found_s;
          do_ack_t = !found_s;
          res_ok   = 1'b1;
        end
      end
      eas_pkg::OP_GET_SERIAL: begin
        if (s_in_range && ser_valid_q[s_sel]) begin
          res_ok   = 1'b1;
          res_id   = ser_id_q[s_sel];
          res_rev  = ser_rev_q[s_sel];
          res_req  = ser_req_q[s_sel];
          res_done = ser_done_q[s_sel];
        end
      end
      eas_pkg::OP_GET_TEMP: begin
        if (t_in_range && tmp_valid_q[t_sel]) begin
          res_ok   = 1'b1;
          res_id   = tmp_id_q[t_sel];
          res_rev  = tmp_rev_q[t_sel];
          res_req  = tmp_req_q[t_sel];
          res_done = tmp_done_q[t_sel];
          res_chg  = tmp_chg_q[t_sel];
        end
      end
      default: ;
    endcase
  end

  // Next valid bits: set on raise, clear once every required consumer acked.
  always_comb begin
    ser_valid_d = ser_valid_q;
    tmp_valid_d = tmp_valid_q;
    if (do_ser_raise) ser_valid_d[s_sel] = 1'b1;
    if (do_tmp_raise) tmp_valid_d[t_sel] = 1'b1;
    if (do_ack_s && ack_complete) ser_valid_d = ser_valid_q & ~s_first;
    if (do_ack_t && ack_complete) tmp_valid_d = tmp_valid_q & ~t_first;
  end

  assign cfg_v = cfg_data_i & ((cfg_idx_i == eas_pkg::CFG_CHG_ALLOWED) ? CHG_MASK : CONS_MASK);

  // Control state: masks, counter, valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_req_mask_q <= MW'(1) & CONS_MASK;
      tmp_req_mask_q <= CONS_MASK;
      tmp_sup_mask_q <= CONS_MASK;
      chg_allow_q    <= CHG_MASK;
      next_id_q      <= '0;
      ser_valid_q    <= '0;
      tmp_valid_q    <= '0;
    end else begin
      if (cfg_we_i && (cfg_v != '0)) begin
        unique case (cfg_idx_i)
          eas_pkg::CFG_SERIAL_REQ: ser_req_mask_q <= cfg_v;
          eas_pkg::CFG_TEMP_REQ: begin
            if (((cfg_v & ~tmp_sup_mask_q) == '0) && !(|tmp_valid_q)) begin
              tmp_req_mask_q <= cfg_v;
            end
          end
          eas_pkg::CFG_TEMP_SUP:    tmp_sup_mask_q <= cfg_v;
          eas_pkg::CFG_CHG_ALLOWED: chg_allow_q    <= cfg_v;
          default: ;
        endcase
      end
      if (cmd_i.execute) begin
        if (do_ser_raise || do_tmp_raise) next_id_q <= new_id;
        ser_valid_q <= ser_valid_d;
        tmp_valid_q <= tmp_valid_d;
      end
    end
  end

  // Payload: latched item, slot stores, result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= opcode_i;
      idx_q <= slot_index_i;
      rev_q <= revision_i;
      chg_q <= change_bits_i;
      eid_q <= ack_event_id_i;
      cm_q  <= consumer_mask_i;
    end
    if (cmd_i.execute) begin
      if (do_ser_raise) begin
        ser_id_q[s_sel]   <= new_id;
        ser_rev_q[s_sel]  <= rev_q;
        ser_req_q[s_sel]  <= ser_req_mask_q;
        ser_done_q[s_sel] <= '0;
      end
      if (do_tmp_raise) begin
        tmp_id_q[t_sel]   <= new_id;
        tmp_rev_q[t_sel]  <= rev_q;
        tmp_req_q[t_sel]  <= tmp_req_mask_q;
        tmp_done_q[t_sel] <= '0;
        tmp_chg_q[t_sel]  <= chg_q;
      end
      for (int i = 0; i < SERIAL_PORTS; i++) begin
        if (do_ack_s && s_first[i]) ser_done_q[i] <= new_done;
      end
      for (int i = 0; i < TEMP_CHANNELS; i++) begin
        if (do_ack_t && t_first[i]) tmp_done_q[i] <= new_done;
      end
      ok_o              <= res_ok;
      out_event_id_o    <= res_id;
      out_revision_o    <= res_rev;
      out_required_o    <= res_req;
      out_completed_o   <= res_done;
      out_change_bits_o <= res_chg;
    end
  end

  // Pending bitmaps show the first four slots of each kind.
  for (genvar g = 0; g < eas_pkg::PEND_W; g++) begin : g_pend
    if (g < SERIAL_PORTS) begin : g_ser
      assign serial_pending_o[g] = ser_valid_q[g];
    end else begin : g_ser_none
      assign serial_pending_o[g] = 1'b0;
    end
    if (g < TEMP_CHANNELS) begin : g_tmp
      assign temp_pending_o[g] = tmp_valid_q[g];
    end else begin : g_tmp_none
      assign temp_pending_o[g] = 1'b0;
    end
  end

endmodule

### sv/event_ack_scoreboard.sv
// Top level of the event acknowledge scoreboard.
// Depends on eas_pkg, eas_ctrl, eas_dp and event_ack_scoreboard_defines.svh.
`timescale 1ns / 1ps
`include "event_ack_scoreboard_defines.svh"

// Usage:
//  - Command channel: drive the item fields with start high; the item is
//    taken at a rising edge where start is high and busy is low.
//  - busy rises for one cycle while the item executes: the id compare over
//    all serial and temperature slots, the acknowledge check and the slot
//    update all resolve in that single execute cycle.
//  - Result channel: the cycle after execute, result_valid_o pulses for one
//    cycle with ok_o, the read-back fields and the pending bitmaps. The
//    receiver cannot hold a result off; sample it on that cycle.
//  - Each item passes the capture registers, the execute state and the result
//    registers in that order; no new item is taken while busy is high.
//  - Configuration: cfg_we_i writes cfg_data_i, clipped, to mask cfg_idx_i at
//    once unless zero (temp required: only a subset of the supported mask,
//    no temp slot pending); write only while no item is in flight.
//  - Reset: all slots free, the id counter at zero (first id is 1), masks
//    at their defaults; the slot payload stores hold no reset value and are
//    read only while their slot is pending.
module event_ack_scoreboard #(
  parameter int SERIAL_PORTS  = eas_pkg::DEF_SERIAL_PORTS,
  parameter int TEMP_CHANNELS = eas_pkg::DEF_TEMP_CHANNELS,
  parameter int CONSUMERS     = eas_pkg::DEF_CONSUMERS,
  parameter int CHANGE_BITS   = eas_pkg::DEF_CHANGE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic [eas_pkg::OP_W-1:0]      opcode_i,
  input  logic [eas_pkg::SLOT_W-1:0]    slot_index_i,
  input  logic [eas_pkg::REV_W-1:0]     revision_i,
  input  logic [eas_pkg::MASK_W-1:0]    change_bits_i,
  input  logic [eas_pkg::ID_W-1:0]      ack_event_id_i,
  input  logic [eas_pkg::MASK_W-1:0]    consumer_mask_i,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [eas_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [eas_pkg::MASK_W-1:0]    cfg_data_i,
  // result channel
  output logic                          result_valid_o,
  output logic                          ok_o,
  output logic [eas_pkg::ID_W-1:0]      out_event_id_o,
  output logic [eas_pkg::REV_W-1:0]     out_revision_o,
  output logic [eas_pkg::MASK_W-1:0]    out_required_o,
  output logic [eas_pkg::MASK_W-1:0]    out_completed_o,
  output logic [eas_pkg::MASK_W-1:0]    out_change_bits_o,
  output logic [eas_pkg::PEND_W-1:0]    serial_pending_o,
  output logic [eas_pkg::PEND_W-1:0]    temp_pending_o
);

  eas_pkg::ctrl_cmd_t cmd;

  // Sequence each item: capture, then execute, then strobe the result.
  eas_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .cmd_o          (cmd)
  );

  // Hold slot state, masks and the id counter; register each result.
  eas_dp #(
    .SERIAL_PORTS  (SERIAL_PORTS),
    .TEMP_CHANNELS (TEMP_CHANNELS),
    .CONSUMERS     (CONSUMERS),
    .CHANGE_BITS   (CHANGE_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .opcode_i          (opcode_i),
    .slot_index_i      (slot_index_i),
    .revision_i        (revision_i),
    .change_bits_i     (change_bits_i),
    .ack_event_id_i    (ack_event_id_i),
    .consumer_mask_i   (consumer_mask_i),
    .ok_o              (ok_o),
    .out_event_id_o    (out_event_id_o),
    .out_revision_o    (out_revision_o),
    .out_required_o    (out_required_o),
    .out_completed_o   (out_completed_o),
    .out_change_bits_o (out_change_bits_o),
    .serial_pending_o  (serial_pending_o),
    .temp_pending_o    (temp_pending_o)
  );

  // An accepted item executes in the next cycle.
  `EAS_ASSERT(a_accept_exec, start && !busy |=> busy, "accepted item did not execute")
  // Every execute cycle yields exactly one result strobe.
  `EAS_ASSERT(a_exec_result, busy |=> result_valid_o && !busy, "execute gave no result")
  // A refused item carries no event id.
  `EAS_ASSERT(a_fail_zero, result_valid_o && !ok_o |-> out_event_id_o == '0,
              "refused item carries an id")
  // Controller and result strobe never overlap.
  `EAS_ASSERT_ALWAYS(a_strobe_idle, !(result_valid_o && busy), "strobe while busy")

endmodule
